// ----- hdl/sbpm_pkg.sv -----
// ----------------------------------------------------------------------------
// sbpm_pkg - shared types and constants
// Defaults, register codes, sequencer states and inter-module structs for
// the band peak meter.
// ----------------------------------------------------------------------------
package sbpm_pkg;

	localparam int LED_COUNT_DEF     = 128;
	localparam int MAX_BAND_BINS_DEF = 1024;
	localparam int FRAC_BITS_DEF     = 16;

	localparam logic [7:0] DECAY_RST      = 8'd230;
	localparam logic [7:0] MIN_BRIGHT_RST = 8'd32;

	// register select (paddr[2])
	localparam logic REG_DECAY      = 1'b0;
	localparam logic REG_MIN_BRIGHT = 1'b1;

	// floor(x/100) = (x*DIV100_MUL) >> DIV100_SHIFT for x < 2^15
	localparam int DIV100_MUL   = 41944;
	localparam int DIV100_SHIFT = 22;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_COLOR,
		ST_WAIT_OUT,
		ST_PEAK
	} seq_state_t;

	typedef struct packed {
		logic [7:0] color;
		logic [7:0] target;
	} color_res_t;

	typedef struct packed {
		logic [7:0] target;
		logic [7:0] decay;
		logic [7:0] floor_lvl;
	} peak_req_t;

endpackage

// ----- hdl/sbpm_accum.sv -----
// ----------------------------------------------------------------------------
// sbpm_accum - band power accumulator
// Three-stage pipe: squared magnitude, weighting, saturating accumulate.
// ----------------------------------------------------------------------------
module sbpm_accum #(
	parameter int MAX_BAND_BINS = sbpm_pkg::MAX_BAND_BINS_DEF,
	parameter int CNT_W         = $clog2(MAX_BAND_BINS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [6:0]       led,
	input  logic [17:0]      re,
	input  logic [17:0]      im,
	input  logic [15:0]      weight,
	input  logic             last,
	output logic             band_valid,
	output logic [31:0]      band_sum,
	output logic [CNT_W-1:0] band_count,
	output logic [6:0]       band_led,
	output logic             last_pending
);
	import sbpm_pkg::*;

	logic [17:0] abs_re, abs_im;
	logic [35:0] magsq_s1;
	logic [15:0] weight_s1;
	logic [6:0]  led_s1, led_s2;
	logic        valid_s1, valid_s2, last_s1, last_s2;
	logic [51:0] prod_s2;
	logic [31:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic [52:0] acc;
	logic [31:0] sum_next;
	logic [CNT_W-1:0] count_next;
	logic        band_valid_q;
	logic [31:0] band_sum_q;
	logic [CNT_W-1:0] band_count_q;
	logic [6:0]  band_led_q;

	assign abs_re = re[17] ? (~re + 18'd1) : re;
	assign abs_im = im[17] ? (~im + 18'd1) : im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			last_s1  <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			valid_s1 <= fire;
			valid_s2 <= valid_s1;
			last_s1  <= fire & last;
			last_s2  <= valid_s1 & last_s1;
		end
	end

	always_ff @(posedge clk) begin
		magsq_s1  <= 36'(abs_re) * 36'(abs_re) + 36'(abs_im) * 36'(abs_im);
		weight_s1 <= weight;
		led_s1    <= led;
		prod_s2   <= 52'(magsq_s1) * 52'(weight_s1);
		led_s2    <= led_s1;
	end

	assign acc        = 53'(sum_q) + 53'(prod_s2);
	assign sum_next   = (|acc[52:32]) ? 32'hFFFF_FFFF : acc[31:0];
	assign count_next = (count_q == CNT_W'(MAX_BAND_BINS)) ? count_q : count_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			count_q      <= '0;
			band_valid_q <= 1'b0;
		end else begin
			band_valid_q <= valid_s2 & last_s2;
			if (valid_s2) begin
				if (last_s2) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_next;
					count_q <= count_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && last_s2) begin
			band_sum_q   <= sum_next;
			band_count_q <= count_next;
			band_led_q   <= led_s2;
		end
	end

	assign band_valid   = band_valid_q;
	assign band_sum     = band_sum_q;
	assign band_count   = band_count_q;
	assign band_led     = band_led_q;
	assign last_pending = last_s1 | last_s2 | band_valid_q;

endmodule

// ----- hdl/sbpm_div.sv -----
// ----------------------------------------------------------------------------
// sbpm_div - band power divider
// Restoring division, one quotient bit a cycle: (sum << FRAC_BITS)/(n*1000).
// ----------------------------------------------------------------------------
module sbpm_div #(
	parameter int FRAC_BITS = sbpm_pkg::FRAC_BITS_DEF,
	parameter int CNT_W     = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [31:0]      sum,
	input  logic [CNT_W-1:0] count,
	output logic             done,
	output logic [31:0]      quot
);
	import sbpm_pkg::*;

	localparam int NUM_W  = 32 + FRAC_BITS;
	localparam int DEN_W  = CNT_W + 10;
	localparam int ITER_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  rem_q, den_q;
	logic [DEN_W:0]    shifted;
	logic [DEN_W:0]    diff;
	logic              qbit;
	logic [ITER_W-1:0] iter_q;
	logic              busy_q, done_q;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign qbit    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(NUM_W);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {sum, FRAC_BITS'(0)};
			rem_q <= '0;
			den_q <= DEN_W'(count) * DEN_W'(1000);
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], qbit};
			rem_q <= qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = (|num_q[NUM_W-1:32]) ? 32'hFFFF_FFFF : num_q[31:0];

endmodule

// ----- hdl/sbpm_color.sv -----
// ----------------------------------------------------------------------------
// sbpm_color - colour index and brightness target
// log2 by repeated squaring of the mantissa, one square a cycle; the
// brightness target runs alongside in registered steps.
// ----------------------------------------------------------------------------
module sbpm_color #(
	parameter int FRAC_BITS = sbpm_pkg::FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [31:0]             psd,
	output logic                    done,
	output sbpm_pkg::color_res_t    res
);
	import sbpm_pkg::*;

	localparam int MSB_W = $clog2(FRAC_BITS + 1);
	localparam int SQ_W  = 2 * FRAC_BITS + 4;
	localparam int HP_W  = SQ_W + 12;
	localparam logic [31:0]     ONE  = 32'(1) << FRAC_BITS;
	localparam logic [31:0]     LOW  = 32'(1) << (FRAC_BITS - 8);
	localparam logic [31:0]     FOUR = 32'(4) << FRAC_BITS;
	localparam logic [SQ_W-1:0] CAP  = SQ_W'(10) << (2 * FRAC_BITS);

	logic [MSB_W-1:0] msb_c, msb_q;
	logic [4:0]       sh_c;
	logic [31:0]      psd_q, m_q;
	logic [63:0]      sqr;
	logic [15:0]      frac_q;
	logic [4:0]       iter_q;
	logic             busy_q, done_q, sat_q, zero_q;
	logic [FRAC_BITS+1:0] psd_small;
	logic [SQ_W-1:0]  sq_c, sq_q;
	logic [HP_W-1:0]  hprod;
	logic [15:0]      hi_q;
	logic [31:0]      tmul;
	logic [9:0]       tq;
	logic [19:0]      lq;
	logic [27:0]      cmul;
	color_res_t       res_q;

	always_comb begin
		msb_c = MSB_W'(FRAC_BITS - 8);
		for (int i = FRAC_BITS - 7; i <= FRAC_BITS; i++) begin
			if (psd[i])
				msb_c = MSB_W'(i);
		end
	end
	assign sh_c = 5'd31 - 5'(msb_c);

	assign sqr       = 64'(m_q) * 64'(m_q);
	assign psd_small = psd_q[FRAC_BITS+1:0];
	assign sq_c      = SQ_W'(psd_small) * SQ_W'(psd_small);
	assign hprod     = HP_W'(sq_q) * HP_W'(2550);
	assign tmul      = 32'(hi_q) * 32'(DIV100_MUL);
	assign tq        = tmul[31:DIV100_SHIFT];
	assign lq        = {4'(msb_q - MSB_W'(FRAC_BITS - 8)), frac_q};
	assign cmul      = 28'(lq) * 28'(255);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= 5'd16;
			end else if (busy_q) begin
				if (iter_q != 5'd0) begin
					iter_q <= iter_q - 5'd1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			psd_q  <= psd;
			msb_q  <= msb_c;
			m_q    <= psd << sh_c;
			frac_q <= '0;
			sat_q  <= (psd > ONE);
			zero_q <= (psd <= LOW);
		end else if (busy_q && iter_q != 5'd0) begin
			// mantissa squared; overflow past 2 renormalises and yields a 1
			if (sqr[63]) begin
				m_q    <= sqr[63:32];
				frac_q <= {frac_q[14:0], 1'b1};
			end else begin
				m_q    <= sqr[62:31];
				frac_q <= {frac_q[14:0], 1'b0};
			end
		end
		sq_q <= (psd_q >= FOUR || sq_c > CAP) ? CAP : sq_c;
		hi_q <= 16'(hprod >> (2 * FRAC_BITS)) + 16'd255;
		if (busy_q && iter_q == 5'd0) begin
			res_q.target <= (tq > 10'd255) ? 8'd255 : tq[7:0];
			if (sat_q)
				res_q.color <= 8'd255;
			else if (zero_q)
				res_q.color <= 8'd0;
			else
				res_q.color <= cmul[26:19];
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- hdl/sbpm_peak.sv -----
// ----------------------------------------------------------------------------
// sbpm_peak - per-LED peak-hold store
// Peak levels in a one-port-write, registered-read memory; clearing sweep
// after reset, then read-modify-write per band.
// ----------------------------------------------------------------------------
module sbpm_peak #(
	parameter int LED_COUNT = sbpm_pkg::LED_COUNT_DEF,
	parameter int ADDR_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ADDR_W-1:0]     addr,
	input  sbpm_pkg::peak_req_t   req,
	output logic                  done,
	output logic [7:0]            brightness,
	output logic                  clear_busy
);
	import sbpm_pkg::*;

	logic [7:0]        mem [LED_COUNT];
	logic [7:0]        rd_q;
	logic [ADDR_W-1:0] addr_q, clr_addr_q, waddr;
	peak_req_t         req_q;
	logic              rmw_s1, done_q, clr_busy_q, we;
	logic [15:0]       dmul;
	logic [7:0]        new_peak, wdata;
	logic [7:0]        bright_q;

	assign dmul     = 16'(rd_q) * 16'(req_q.decay);
	assign new_peak = (req_q.target > rd_q) ? req_q.target : dmul[15:8];
	assign we       = clr_busy_q | rmw_s1;
	assign waddr    = clr_busy_q ? clr_addr_q : addr_q;
	assign wdata    = clr_busy_q ? 8'd0 : new_peak;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			rmw_s1     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			rmw_s1 <= start;
			done_q <= rmw_s1;
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				if (clr_addr_q == ADDR_W'(LED_COUNT - 1))
					clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			addr_q <= addr;
			req_q  <= req;
		end
		if (rmw_s1)
			bright_q <= (new_peak > req_q.floor_lvl) ? new_peak : req_q.floor_lvl;
	end

	assign done       = done_q;
	assign brightness = bright_q;
	assign clear_busy = clr_busy_q;

endmodule

// ----- hdl/spectrum_band_peak_meter_top.sv -----
// ----------------------------------------------------------------------------
// spectrum_band_peak_meter_top - spectrum band level meter with peak decay
// FFT bins in, one brightness/colour request per LED band out.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one FFT bin per request; tlast marks the final bin of a
//  band and the led_index of that bin selects the LED. m_axis carries one
//  request per band closed on an LED below LED_COUNT; other bands are dropped.
//  Bins that do not close a band are taken one per cycle while the sequencer
//  is idle and no closing bin is still in flight. A closing bin runs through
//  the 3-stage accumulator and then the band back end: the bit-serial
//  divider, the log2 squaring loop, the wait for a free output register and
//  the peak update. s_axis_tready stays low until that band is through.
//  Reset clears the accumulators and sweeps the peak memory to zero, one
//  LED a cycle; s_axis_tready stays low until the sweep is done.
//  APB writes to the two registers are taken at any time.
//  A stalled m_axis holds its request in the output register; the next band
//  is accumulated meanwhile and waits before its peak update until the
//  register is free.
// ----------------------------------------------------------------------------
module spectrum_band_peak_meter_top #(
	parameter int LED_COUNT     = sbpm_pkg::LED_COUNT_DEF,
	parameter int MAX_BAND_BINS = sbpm_pkg::MAX_BAND_BINS_DEF,
	parameter int FRAC_BITS     = sbpm_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// bins in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [6:0] led_index, [24:7] bin_real, [42:25] bin_imag, [58:43] weight
	input  logic [63:0] s_axis_tdata,
	input  logic        s_axis_tlast,   // last_bin
	// results out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [6:0] led_out, [14:7] brightness, [22:15] color_index
	output logic [23:0] m_axis_tdata,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sbpm_pkg::*;

	localparam int CNT_W  = $clog2(MAX_BAND_BINS + 1);
	localparam int ADDR_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	seq_state_t state_q, state_d;

	logic [7:0] decay_q, min_bright_q;
	logic       in_fire, band_valid, last_pending, led_ok;
	logic [31:0] band_sum;
	logic [CNT_W-1:0] band_count;
	logic [6:0] band_led, led_q;
	logic       div_start, div_done, color_start, color_done;
	logic       peak_start, peak_done, clear_busy;
	logic [31:0] psd;
	color_res_t color_res;
	peak_req_t  peak_req;
	logic [7:0] peak_bright;
	logic       in_ready;
	logic       out_valid_q;
	logic [23:0] out_data_q;

	// register port: always ready, word select on paddr[2]
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q      <= DECAY_RST;
			min_bright_q <= MIN_BRIGHT_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_DECAY:      decay_q      <= pwdata[7:0];
				REG_MIN_BRIGHT: min_bright_q <= pwdata[7:0];
				default:        ;
			endcase
		end
	end
	always_comb begin
		case (paddr[2])
			REG_DECAY:      prdata = {24'd0, decay_q};
			REG_MIN_BRIGHT: prdata = {24'd0, min_bright_q};
			default:        prdata = '0;
		endcase
	end

	assign in_fire = s_axis_tvalid & in_ready;

	sbpm_accum #(
		.MAX_BAND_BINS(MAX_BAND_BINS),
		.CNT_W        (CNT_W)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (in_fire),
		.led         (s_axis_tdata[6:0]),
		.re          (s_axis_tdata[24:7]),
		.im          (s_axis_tdata[42:25]),
		.weight      (s_axis_tdata[58:43]),
		.last        (s_axis_tlast),
		.band_valid  (band_valid),
		.band_sum    (band_sum),
		.band_count  (band_count),
		.band_led    (band_led),
		.last_pending(last_pending)
	);

	// bands on a missing LED are dropped here
	assign led_ok = (32'(band_led) < 32'(LED_COUNT));

	sbpm_div #(
		.FRAC_BITS(FRAC_BITS),
		.CNT_W    (CNT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.sum   (band_sum),
		.count (band_count),
		.done  (div_done),
		.quot  (psd)
	);

	sbpm_color #(
		.FRAC_BITS(FRAC_BITS)
	) u_color (
		.clk   (clk),
		.arst_n(arst_n),
		.start (color_start),
		.psd   (psd),
		.done  (color_done),
		.res   (color_res)
	);

	assign peak_req.target    = color_res.target;
	assign peak_req.decay     = decay_q;
	assign peak_req.floor_lvl = min_bright_q;

	// one band in the back end at a time, so the peak RMW never overlaps itself
	sbpm_peak #(
		.LED_COUNT(LED_COUNT),
		.ADDR_W   (ADDR_W)
	) u_peak (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (peak_start),
		.addr      (ADDR_W'(led_q)),
		.req       (peak_req),
		.done      (peak_done),
		.brightness(peak_bright),
		.clear_busy(clear_busy)
	);

	// band sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:    if (!clear_busy) state_d = ST_IDLE;
			ST_IDLE:     if (band_valid && led_ok) state_d = ST_DIV;
			ST_DIV:      if (div_done) state_d = ST_COLOR;
			ST_COLOR:    if (color_done) state_d = ST_WAIT_OUT;
			ST_WAIT_OUT: if (!out_valid_q) state_d = ST_PEAK;
			ST_PEAK:     if (peak_done) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		div_start   = 1'b0;
		color_start = 1'b0;
		peak_start  = 1'b0;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = ~last_pending;
				div_start = band_valid & led_ok;
			end
			ST_DIV:      color_start = div_done;
			ST_WAIT_OUT: peak_start  = ~out_valid_q;
			default:     ;
		endcase
	end

	assign s_axis_tready = in_ready;

	always_ff @(posedge clk) begin
		if (div_start)
			led_q <= band_led;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (peak_done)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (peak_done)
			out_data_q <= {1'b0, color_res.color, peak_bright, led_q};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// a closed band only arrives while the back end is free
	a_band_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		band_valid |-> (state_q == ST_IDLE))
		else $error("band closed while back end busy");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its step");

	a_color_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		color_done |-> (state_q == ST_COLOR))
		else $error("colour unit finished outside its step");

	a_peak_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		peak_done |=> m_axis_tvalid)
		else $error("peak update produced no result");

endmodule

// ----- bench/tb_spectrum_band_peak_meter_top.sv -----
// ----------------------------------------------------------------------------
// tb_spectrum_band_peak_meter_top - self-checking bench for the band meter
// FFT bins are streamed in bands with random bursts and gaps while the result
// side stalls on its own pattern, once for a long stretch. A predictor of
// band power, colour index and peak-hold brightness checks every result
// request. Several register settings run in separate phases.
// ----------------------------------------------------------------------------
module tb_spectrum_band_peak_meter_top;
	import sbpm_pkg::*;

	localparam int LEDS      = LED_COUNT_DEF;
	localparam int MAX_BINS  = MAX_BAND_BINS_DEF;
	localparam int FRAC      = FRAC_BITS_DEF;
	localparam int DRAIN_CYC = 150;
	localparam int LIMIT_CYC = 600000;
	localparam int HOLD_CYC  = 2000;       // long receiver hold-off

	typedef struct {
		bit [6:0]         led;
		bit signed [17:0] re;
		bit signed [17:0] im;
		bit [15:0]        w;
		bit               last;
	} bin_t;

	typedef struct {
		bit [6:0] led;
		bit [7:0] bright;
		bit [7:0] color;
	} level_t;

	logic        clk, arst_n;
	logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid, m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;

	spectrum_band_peak_meter_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// pending bins (front is the one on the bus) and expected levels
	bin_t   bin_q[$];
	level_t level_q[$];
	int     errors;
	int     cycles;
	bit     hold_req;          // set once to ask for the long hold-off
	bit     bin_taken;         // bin request accepted at the last rising edge

	// predictor state
	bit [31:0] band_sum;
	int        band_bins;
	bit [7:0]  peak_mem[LEDS];
	bit [7:0]  decay_r, floor_r;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input int unsigned exp_v, input int unsigned got_v);
		$display("mismatch %s: expected %0d got %0d at cycle %0d", what, exp_v, got_v, cycles);
		errors++;
	endtask

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic longint unsigned mag18(input bit signed [17:0] v);
		longint x;
		x = longint'(v);
		return (x < 0) ? longint'(-x) : longint'(x);
	endfunction

	// log2 colour index of Q.FRAC band power
	function automatic bit [7:0] colour_of(input longint unsigned p);
		int unsigned     msb;
		longint unsigned m, frac, lq;
		msb  = 0;
		frac = 0;
		if (p > (64'd1 << FRAC))
			return 8'd255;
		if (p <= (64'd1 << (FRAC - 8)))
			return 8'd0;
		while (msb < 63 && (p >> (msb + 1)) != 0)
			msb++;
		m = p << (31 - msb);
		repeat (16) begin
			m    = (m * m) >> 31;
			frac = frac << 1;
			if (m >= (64'd2 << 31)) begin
				m    = m >> 1;
				frac = frac | 1;
			end
		end
		lq = (longint'(msb + 8 - FRAC) << 16) | frac;
		return 8'((lq * 255) >> 19);
	endfunction

	// brightness target: 255*(min(psd^2,10)+0.1)/10, exact
	function automatic bit [7:0] target_of(input longint unsigned p);
		longint unsigned unit_v, cap, s, b;
		unit_v = 64'd1 << (2 * FRAC);
		cap    = 10 * unit_v;
		if (p >= (64'd4 << FRAC)) begin
			s = cap;
		end else begin
			s = p * p;
			if (s > cap)
				s = cap;
		end
		b = (2550 * s + 255 * unit_v) / (100 * unit_v);
		return (b > 255) ? 8'd255 : 8'(b);
	endfunction

	function automatic void predict_bin(input bin_t b);
		longint unsigned acc, p, re, im;
		level_t          lv;
		bit [7:0]        tgt, pk;
		re  = mag18(b.re);
		im  = mag18(b.im);
		acc = longint'(band_sum) + longint'(b.w) * (re * re + im * im);
		band_sum = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
		if (band_bins < MAX_BINS)
			band_bins++;
		if (!b.last)
			return;
		p = (longint'(band_sum) << FRAC) / (longint'(band_bins) * 1000);
		if (p > 64'hFFFF_FFFF)
			p = 64'hFFFF_FFFF;
		band_sum  = 0;
		band_bins = 0;
		if (b.led >= LEDS)
			return;
		tgt = target_of(p);
		pk  = peak_mem[b.led];
		if (tgt > pk)
			pk = tgt;
		else
			pk = 8'((int'(pk) * int'(decay_r)) >> 8);
		peak_mem[b.led] = pk;
		lv.led    = b.led;
		lv.bright = (pk > floor_r) ? pk : floor_r;
		lv.color  = colour_of(p);
		level_q.push_back(lv);
	endfunction

	// ------------------------------------------------------------------------
	// Driver: bursts of bins with random gaps
	// ------------------------------------------------------------------------
	int burst_left, gap_left;

	always @(negedge clk) begin
		if (arst_n) begin
			if (bin_taken)
				void'(bin_q.pop_front());
			if (s_axis_tvalid && !bin_taken) begin
				// request still pending, hold it
			end else if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (bin_q.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {5'd0, bin_q[0].w, bin_q[0].im, bin_q[0].re, bin_q[0].led};
				s_axis_tlast  <= bin_q[0].last;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: stall pattern picked at random from three modes; one long hold-off
	// ------------------------------------------------------------------------
	int hold_left, rx_mode;

	always @(negedge clk) begin
		if (cycles % 64 == 0)
			rx_mode = $urandom_range(0, 2);
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYC;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 0);
				default: m_axis_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: sample both handshakes on the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		level_t lv;
		cycles++;
		if (cycles > LIMIT_CYC) begin
			$display("timeout at cycle %0d", cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			bin_taken = s_axis_tvalid && s_axis_tready;
			if (bin_taken)
				predict_bin(bin_q[0]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (level_q.size() == 0) begin
					report("unexpected result led", 0, m_axis_tdata[6:0]);
				end else begin
					lv = level_q.pop_front();
					if (m_axis_tdata[6:0] != lv.led)
						report("led_out", lv.led, m_axis_tdata[6:0]);
					if (m_axis_tdata[14:7] != lv.bright)
						report("brightness", lv.bright, m_axis_tdata[14:7]);
					if (m_axis_tdata[22:15] != lv.color)
						report("color_index", lv.color, m_axis_tdata[22:15]);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic add_bin(input int led, input int re, input int im, input int w,
			input bit last);
		bin_t b;
		b.led  = 7'(led);
		b.re   = 18'(re);
		b.im   = 18'(im);
		b.w    = 16'(w);
		b.last = last;
		bin_q.push_back(b);
	endtask

	// random band; the size class keeps psd mostly in the interesting range
	task automatic add_band();
		int len, cls, led, lim, wmax;
		len  = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
		led  = $urandom_range(0, LEDS - 1);
		cls  = $urandom_range(0, 9);
		lim  = (cls < 5) ? 40 : (cls < 8) ? 300 : 131071;
		wmax = (cls < 5) ? 4 : (cls < 8) ? 64 : 65535;
		for (int i = 0; i < len; i++) begin
			if (cls == 9)
				add_bin(led, $urandom, $urandom, $urandom, i == len - 1);
			else
				add_bin(led, $urandom_range(0, 2 * lim) - lim,
					$urandom_range(0, 2 * lim) - lim, $urandom_range(0, wmax),
					i == len - 1);
		end
	endtask

	// register write: setup then access cycle; predictor follows at the edge
	task automatic reg_write(input logic sel, input bit [7:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= {16'($urandom_range(0, 16'hFFFF)), 8'($urandom), val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (sel == REG_DECAY)
			decay_r = val;
		else
			floor_r = val;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait until every bin is taken and every level has come out
	task automatic drain();
		while (bin_q.size() != 0 || level_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		int sent;
		bit hold_done;
		errors        = 0;
		cycles        = 0;
		hold_req      = 1'b0;
		hold_done     = 1'b0;
		hold_left     = 0;
		rx_mode       = 0;
		bin_taken     = 1'b0;
		burst_left    = 1;
		gap_left      = 0;
		band_sum      = 0;
		band_bins     = 0;
		decay_r       = DECAY_RST;
		floor_r       = MIN_BRIGHT_RST;
		foreach (peak_mem[i]) peak_mem[i] = 8'd0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 64'd0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = 3'd0;
		pwdata        = 32'd0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset registers first
		add_bin(0, 0, 0, 0, 1'b1);                    // zero power
		add_bin(127, -131072, 131071, 65535, 1'b0);   // saturating sum
		add_bin(127, -131072, -131072, 65535, 1'b1);
		add_bin(5, 10, 30, 1, 1'b1);                  // psd exactly 1.0
		add_bin(6, 60, -20, 1, 1'b1);                 // psd exactly 4.0
		add_bin(7, 1, 1, 2, 1'b1);                    // just above the colour floor
		add_bin(7, 0, 0, 0, 1'b1);                    // decay of LED 7
		add_bin(8, 131071, 0, 1, 1'b0);
		add_bin(8, 0, -131071, 0, 1'b1);
		drain();

		// directed: both extremes of the registers
		reg_write(REG_DECAY, 8'd0);
		reg_write(REG_MIN_BRIGHT, 8'd0);
		add_bin(127, 0, 0, 0, 1'b1);
		add_bin(127, 0, 0, 0, 1'b1);
		add_bin(5, 10, 30, 1, 1'b1);
		add_bin(5, 3, 4, 1, 1'b1);
		drain();
		reg_write(REG_DECAY, 8'd255);
		reg_write(REG_MIN_BRIGHT, 8'd255);
		add_bin(6, 60, -20, 1, 1'b1);
		add_bin(6, 1, 0, 1, 1'b1);
		add_bin(0, -1, -1, 65535, 1'b1);
		drain();

		// band longer than the bin counter
		reg_write(REG_DECAY, 8'd128);
		reg_write(REG_MIN_BRIGHT, 8'd10);
		for (int i = 0; i < MAX_BINS + 6; i++)
			add_bin(9, $urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100,
				$urandom_range(0, 60), i == MAX_BINS + 5);
		drain();

		// random phases; all but the first write new register values
		for (int ph = 0; ph < 4; ph++) begin
			if (ph > 0) begin
				reg_write(REG_DECAY, (ph == 1) ? DECAY_RST : 8'($urandom));
				reg_write(REG_MIN_BRIGHT, (ph == 1) ? MIN_BRIGHT_RST : 8'($urandom));
			end
			sent = 0;
			while (sent < 210) begin
				add_band();
				sent = bin_q.size() + sent;
				if (ph == 2 && sent > 40 && !hold_done) begin
					hold_req  = 1'b1;   // receiver holds off while bins keep coming
					hold_done = 1'b1;
				end
				while (bin_q.size() > 20)
					@(posedge clk);
				sent = sent - bin_q.size();
			end
			drain();
		end

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/sbpm_pkg.sv
hdl/sbpm_accum.sv
hdl/sbpm_div.sv
hdl/sbpm_color.sv
hdl/sbpm_peak.sv
hdl/spectrum_band_peak_meter_top.sv
bench/tb_spectrum_band_peak_meter_top.sv
